/* hdl/m2ar_pkg.sv */
// Shared types and constants for the MPEG-2 aspect-ratio patcher.
// No dependencies; imported by m2ar_scan and the top level.
package m2ar_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ASPECT_W = 4;

  localparam logic [ASPECT_W-1:0] ASPECT_RESET  = 4'h2;
  localparam logic [BYTE_W-1:0]   PREFIX_BYTE   = 8'h01;
  localparam logic [BYTE_W-1:0]   SEQ_HDR_CODE  = 8'hB3;

  // Scanner states, one-hot.
  typedef enum logic [9:0] {
    ST_SEARCH     = 10'b00_0000_0001,  // looking for a zero byte
    ST_ZERO1      = 10'b00_0000_0010,  // one zero seen
    ST_ZERO2      = 10'b00_0000_0100,  // two or more zeros seen
    ST_PREFIX     = 10'b00_0000_1000,  // 00 00 01 seen
    ST_FOUND      = 10'b00_0001_0000,  // sequence header code found
    ST_SIZE0      = 10'b00_0010_0000,  // first size byte nonzero
    ST_SIZE1      = 10'b00_0100_0000,  // second size byte passed
    ST_ASPECT     = 10'b00_1000_0000,  // next byte is aspect / frame rate
    ST_SIZE0_ZERO = 10'b01_0000_0000,  // first size byte zero
    ST_SIZE1_ZERO = 10'b10_0000_0000   // second size byte zero
  } scan_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              patched;
  } scan_result_t;

endpackage

/* hdl/m2ar_scan.sv */
// Next-state and patch logic of the start-code scanner, purely combinational.
// Depends on m2ar_pkg.
module m2ar_scan
  import m2ar_pkg::*;
(
  input  scan_state_t         state,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic [ASPECT_W-1:0] aspect_code,
  output scan_state_t         state_next,
  output scan_result_t        result
);

  logic zero;

  assign zero = (in_byte == '0);

  always_comb begin
    state_next      = ST_SEARCH;
    result.out_byte = in_byte;
    result.patched  = 1'b0;
    case (state)
      ST_ZERO1:      state_next = zero ? ST_ZERO2 : ST_SEARCH;
      ST_ZERO2: begin
        if (in_byte == PREFIX_BYTE) state_next = ST_PREFIX;
        else                        state_next = zero ? ST_ZERO2 : ST_SEARCH;
      end
      ST_PREFIX: begin
        if (in_byte == SEQ_HDR_CODE) state_next = ST_FOUND;
        else                         state_next = zero ? ST_ZERO1 : ST_SEARCH;
      end
      ST_FOUND:      state_next = zero ? ST_SIZE0_ZERO : ST_SIZE0;
      ST_SIZE0:      state_next = zero ? ST_SIZE1_ZERO : ST_SIZE1;
      ST_SIZE1:      state_next = ST_ASPECT;
      ST_ASPECT: begin
        if (!zero) begin
          // keep frame-rate nibble, swap in aspect code
          result.out_byte = {aspect_code, in_byte[3:0]};
          result.patched  = 1'b1;
          state_next      = ST_SEARCH;
        end else begin
          state_next = ST_ZERO1;
        end
      end
      ST_SIZE0_ZERO: state_next = zero ? ST_ZERO1 : ST_SIZE1;
      ST_SIZE1_ZERO: state_next = zero ? ST_ZERO1 : ST_ASPECT;
      default:       state_next = zero ? ST_ZERO1 : ST_SEARCH;
    endcase
  end

endmodule

/* hdl/mpeg2_aspect_ratio_patcher.sv */
// Top level of the MPEG-2 aspect-ratio patcher: input register, scanner, output register.
// Depends on m2ar_pkg and m2ar_scan.

// Passes an MPEG-2 video elementary stream through one byte per request and
// rewrites the aspect-ratio code of every sequence header. The scanner looks
// for 00 00 01 B3 (any run of leading zeros is fine), steps over the three
// picture-size bytes, and in the following aspect/frame-rate byte replaces the
// upper nibble with aspect_code when that byte is nonzero; m_axis_tuser marks
// such a byte. A zero byte in that position is passed unchanged and counts as
// the first zero of a new start code. Throughput is one byte per clock while
// m_axis_tready does not stall the output; a byte passes through the input
// register, then the scanner state update and output register. The only loop is
// the scanner state register, updated once per byte. aspect_code resets to 2 and
// should only be written while no bytes are in flight.
module mpeg2_aspect_ratio_patcher
  import m2ar_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  // config
  input  logic                cfg_we,
  input  logic [ASPECT_W-1:0] cfg_wdata,      // aspect_code

  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] in_byte

  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [BYTE_W-1:0]   m_axis_tdata,   // [7:0] out_byte
  output logic                m_axis_tuser    // [0] patched
);

  logic [ASPECT_W-1:0] aspect_code;

  // input register
  logic                in_valid;
  logic [BYTE_W-1:0]   in_byte;

  // output register
  logic                out_valid;
  scan_result_t        out_result;

  scan_state_t         state;
  scan_state_t         state_next;
  scan_result_t        scan_result;

  logic                out_adv;   // output register can load
  logic                move;      // input register hands its byte on

  assign out_adv       = !out_valid || m_axis_tready;
  assign move          = in_valid && out_adv;
  assign s_axis_tready = !in_valid || out_adv;

  m2ar_scan u_scan (
    .state       (state),
    .in_byte     (in_byte),
    .aspect_code (aspect_code),
    .state_next  (state_next),
    .result      (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_code <= ASPECT_RESET;
    end else if (cfg_we) begin
      aspect_code <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // scanner state steps once per byte moved to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEARCH;
    end else if (move) begin
      state <= state_next;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_result <= scan_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.out_byte;
  assign m_axis_tuser  = out_result.patched;

endmodule

/* hdl/m2ar_check.sv */
// Port-level assertions for the aspect-ratio patcher and their bind.
// Depends on the mpeg2_aspect_ratio_patcher ports only.
module m2ar_check (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // with the output register empty the block must take input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // a patched byte restarts the search, so the next byte cannot be patched
  a_no_double_patch: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser)
      |=> !(m_axis_tvalid && m_axis_tuser))
    else $error("two patched bytes in a row");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed while stalled");

endmodule

bind mpeg2_aspect_ratio_patcher m2ar_check u_m2ar_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
